// ----- sv/esm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes of the enclosed span matcher.
// No dependencies; every other file of the block uses this package.
package esm_pkg;

   // Default longest delimiter in bytes. The register fields stay 64 bits wide.
   localparam int unsigned MAX_DELIM_LEN_DEF = 8;
   localparam int unsigned DELIM_BYTES_W     = 64;
   localparam int unsigned LEN_W             = 4;
   localparam int unsigned COUNT_W           = 16;

   // Function codes of a request beat. Code three is ignored.
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_DATA  = 2'd1;
   localparam logic [1:0] FUNC_END   = 2'd2;

   // Verdict codes of a response beat.
   localparam logic VERDICT_ACCEPT = 1'b0;
   localparam logic VERDICT_REJECT = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_OPEN_BYTES  = 2'd0;
   localparam logic [1:0] CSR_OPEN_LEN    = 2'd1;
   localparam logic [1:0] CSR_CLOSE_BYTES = 2'd2;
   localparam logic [1:0] CSR_CLOSE_LEN   = 2'd3;

   // Attempt phase, one-hot.
   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_OPEN  = 3'b010,
      PH_CLOSE = 3'b100
   } phase_type;

   // Request and response payloads.
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic                 verdict;
      logic [COUNT_W-1:0]   consumed_length;
   } rsp_type;

   // Configuration registers.
   typedef struct packed {
      logic [DELIM_BYTES_W-1:0] open_bytes;
      logic [LEN_W-1:0]         open_len;
      logic [DELIM_BYTES_W-1:0] close_bytes;
      logic [LEN_W-1:0]         close_len;
   } cfg_type;

   // Attempt state apart from the closing prefix vector.
   typedef struct packed {
      phase_type           phase;
      logic [LEN_W-1:0]    open_position;
      logic                open_mismatch;
      logic [COUNT_W-1:0]  byte_count;
   } core_state_type;

   // Result of one step: whether a response beat is produced, and its payload.
   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } step_out_type;

endpackage

// ----- sv/esm_step.sv -----
`timescale 1ns / 1ps
// Next-state and result logic of the enclosed span matcher for one request beat.
// Depends on esm_pkg for the payload, configuration and state types.
module esm_step #(
   parameter int unsigned MAX_DELIM_LEN = esm_pkg::MAX_DELIM_LEN_DEF
) (
   input  esm_pkg::cfg_type        cfg,
   input  esm_pkg::req_type        item,
   input  esm_pkg::core_state_type state_cur,
   input  logic [MAX_DELIM_LEN-1:0] prefix_cur,
   output esm_pkg::core_state_type state_next,
   output logic [MAX_DELIM_LEN-1:0] prefix_next,
   output esm_pkg::step_out_type   result
);
   import esm_pkg::*;

   localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_DELIM_LEN);

   logic [LEN_W-1:0]         olen;
   logic [LEN_W-1:0]         clen;
   logic [COUNT_W-1:0]       count_inc;
   logic [7:0]               open_byte;
   logic                     open_miss_next;
   logic [LEN_W-1:0]         open_pos_next;
   logic [MAX_DELIM_LEN-1:0] close_eq;
   logic [MAX_DELIM_LEN-1:0] close_last;
   logic [MAX_DELIM_LEN-1:0] prefix_shift;

   // Lengths above the supported maximum act as the maximum.
   assign olen = (cfg.open_len  > MaxLen) ? MaxLen : cfg.open_len;
   assign clen = (cfg.close_len > MaxLen) ? MaxLen : cfg.close_len;

   // Saturating byte counter.
   assign count_inc = (state_cur.byte_count == {COUNT_W{1'b1}}) ?
                      state_cur.byte_count : state_cur.byte_count + COUNT_W'(1);

   // Opening string compare at the current position.
   assign open_byte      = cfg.open_bytes[state_cur.open_position[2:0]*8 +: 8];
   assign open_miss_next = state_cur.open_mismatch |
                           ((state_cur.open_position < olen) &&
                            (open_byte != item.data_byte));
   assign open_pos_next  = state_cur.open_position + LEN_W'(1);

   // Per-position match of the closing string and the mask of its last byte.
   always_comb begin
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
         close_eq[i]   = (LEN_W'(i) < clen) &&
                         (cfg.close_bytes[i*8 +: 8] == item.data_byte);
         close_last[i] = (LEN_W'(i + 1) == clen);
      end
   end

   // Shift-and update: each partial match extends by one byte.
   assign prefix_shift = MAX_DELIM_LEN'({prefix_cur, 1'b1}) & close_eq;

   // Step of the attempt for one request beat.
   always_comb begin
      state_next  = state_cur;
      prefix_next = prefix_cur;
      result.emit = 1'b0;
      result.rsp.verdict         = VERDICT_ACCEPT;
      result.rsp.consumed_length = state_cur.byte_count;

      unique case (item.func)
         FUNC_START: begin
            state_next.open_position = '0;
            state_next.open_mismatch = 1'b0;
            state_next.byte_count    = '0;
            prefix_next              = '0;
            result.rsp.consumed_length = '0;
            if (olen == '0 && clen == '0) begin
               state_next.phase = PH_IDLE;
               result.emit      = 1'b1;
            end else if (olen != '0) begin
               state_next.phase = PH_OPEN;
            end else begin
               state_next.phase = PH_CLOSE;
            end
         end
         FUNC_END: begin
            if (state_cur.phase != PH_IDLE) begin
               state_next.phase   = PH_IDLE;
               result.emit        = 1'b1;
               result.rsp.verdict = VERDICT_REJECT;
            end
         end
         FUNC_DATA: begin
            unique case (state_cur.phase)
               PH_OPEN: begin
                  state_next.byte_count      = count_inc;
                  state_next.open_mismatch   = open_miss_next;
                  state_next.open_position   = open_pos_next;
                  result.rsp.consumed_length = count_inc;
                  if (open_pos_next >= olen) begin
                     if (open_miss_next) begin
                        state_next.phase   = PH_IDLE;
                        result.emit        = 1'b1;
                        result.rsp.verdict = VERDICT_REJECT;
                     end else if (clen == '0) begin
                        state_next.phase = PH_IDLE;
                        result.emit      = 1'b1;
                     end else begin
                        state_next.phase = PH_CLOSE;
                        prefix_next      = '0;
                     end
                  end
               end
               PH_CLOSE: begin
                  state_next.byte_count      = count_inc;
                  result.rsp.consumed_length = count_inc;
                  if (|(prefix_shift & close_last)) begin
                     prefix_next      = '0;
                     state_next.phase = PH_IDLE;
                     result.emit      = 1'b1;
                  end else begin
                     prefix_next = prefix_shift;
                  end
               end
               default: begin
                  // Data beats outside an attempt are dropped.
               end
            endcase
         end
         default: begin
            // Unused function code: no change.
         end
      endcase
   end

endmodule

// ----- sv/enclosed_span_matcher_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// req_      in   req_valid / req_stall     esm_pkg::req_type (func, data_byte)
// rsp_      out  rsp_valid / rsp_stall     esm_pkg::rsp_type (verdict, consumed_length)
// csr_      in   csr_valid / csr_ready     csr_index, csr_wdata
//
// One request beat per clock while req_stall is low. A beat is registered on acceptance
// and then stepped through the matcher logic once the step stage advances, which also
// loads the response register; a response, if any, is offered from then on.
// The attempt state updates once per beat in that single step, which sets the rate.
// Reset is synchronous and clears the configuration, the attempt state and both valids.
// A stalled response holds the step stage; req_stall rises only then.
// Depends on esm_pkg and esm_step.
module enclosed_span_matcher_unit #(
   parameter int unsigned MAX_DELIM_LEN = esm_pkg::MAX_DELIM_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  esm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output esm_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [esm_pkg::DELIM_BYTES_W-1:0] csr_wdata
);
   import esm_pkg::*;

   cfg_type                  cfg_ff, cfg_in;
   logic                     s1_valid_ff, s1_valid_in;
   req_type                  s1_item_ff, s1_item_in;
   core_state_type           state_ff, state_in;
   logic [MAX_DELIM_LEN-1:0] prefix_ff, prefix_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   core_state_type           state_step;
   logic [MAX_DELIM_LEN-1:0] prefix_step;
   step_out_type             step_res;
   logic                     advance;
   logic                     fire;
   logic                     req_take;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OPEN_BYTES:  cfg_in.open_bytes  = csr_wdata;
            CSR_OPEN_LEN:    cfg_in.open_len    = csr_wdata[LEN_W-1:0];
            CSR_CLOSE_BYTES: cfg_in.close_bytes = csr_wdata;
            CSR_CLOSE_LEN:   cfg_in.close_len   = csr_wdata[LEN_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // The step stage moves when the response register is free or being drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Input register.
   always_comb begin
      s1_item_in  = s1_item_ff;
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_data;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   esm_step #(
      .MAX_DELIM_LEN(MAX_DELIM_LEN)
   ) u_step (
      .cfg        (cfg_ff),
      .item       (s1_item_ff),
      .state_cur  (state_ff),
      .prefix_cur (prefix_ff),
      .state_next (state_step),
      .prefix_next(prefix_step),
      .result     (step_res)
   );

   // Attempt state and response register.
   always_comb begin
      state_in     = state_ff;
      prefix_in    = prefix_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         state_in  = state_step;
         prefix_in = prefix_step;
      end
      if (fire && step_res.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_res.rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         state_ff.phase         <= PH_IDLE;
         state_ff.open_position <= '0;
         state_ff.open_mismatch <= 1'b0;
         state_ff.byte_count    <= '0;
         prefix_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         prefix_ff    <= prefix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/esm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the enclosed span matcher, bound to its top level.
// Depends on esm_pkg for the response payload type.
module esm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input esm_pkg::rsp_type rsp_data
);

   // A stalled response beat stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // A stalled response beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("response payload changed while stalled");

   // A fresh response follows a request beat taken earlier.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("response beat without a request beat");

   // Back-pressure on requests only comes from a held response.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

endmodule

bind enclosed_span_matcher_unit esm_checker u_checker (.*);
